@@ rtl/tag_length_tag_deframer_top_macros.svh @@
// Assertion macros used by the deframer top level.
`ifndef TAG_LENGTH_TAG_DEFRAMER_TOP_MACROS_SVH
`define TAG_LENGTH_TAG_DEFRAMER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tltd_pkg.sv @@
// Shared types and constants of the tag-length-tag deframer.
package tltd_pkg;

    // Field widths and frame layout.
    localparam int BYTE_W    = 8;
    localparam int NUM_TAGS  = 5;
    localparam int MIN_FRAME = 6;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TAG_WRITE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_READ      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_HANDSHAKE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_INIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_SETUP     = 3'd4;

    // Reset values of the tag registers.
    localparam logic [BYTE_W-1:0] RST_TAG_WRITE     = 8'd1;
    localparam logic [BYTE_W-1:0] RST_TAG_READ      = 8'd2;
    localparam logic [BYTE_W-1:0] RST_TAG_HANDSHAKE = 8'd3;
    localparam logic [BYTE_W-1:0] RST_TAG_INIT      = 8'd4;
    localparam logic [BYTE_W-1:0] RST_TAG_SETUP     = 8'd5;

    // One configuration write request.
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    data;
    } t_cfg_wr;

endpackage

@@ rtl/tltd_tag_match.sv @@
// Type tag register file and tag byte matcher.
module tltd_tag_match (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tltd_pkg::t_cfg_wr                i_cfg,
    input  logic [tltd_pkg::BYTE_W-1:0]      i_byte,
    output logic                             o_is_tag
);
    import tltd_pkg::*;

    logic [BYTE_W-1:0] r_tag_write;
    logic [BYTE_W-1:0] r_tag_read;
    logic [BYTE_W-1:0] r_tag_handshake;
    logic [BYTE_W-1:0] r_tag_init;
    logic [BYTE_W-1:0] r_tag_setup;

    // Register writes; indexes past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_write     <= RST_TAG_WRITE;
            r_tag_read      <= RST_TAG_READ;
            r_tag_handshake <= RST_TAG_HANDSHAKE;
            r_tag_init      <= RST_TAG_INIT;
            r_tag_setup     <= RST_TAG_SETUP;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                REG_TAG_WRITE:     r_tag_write     <= i_cfg.data;
                REG_TAG_READ:      r_tag_read      <= i_cfg.data;
                REG_TAG_HANDSHAKE: r_tag_handshake <= i_cfg.data;
                REG_TAG_INIT:      r_tag_init      <= i_cfg.data;
                REG_TAG_SETUP:     r_tag_setup     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // A byte is a tag when it equals any of the configured values.
    assign o_is_tag = (i_byte == r_tag_write)     || (i_byte == r_tag_read) ||
                      (i_byte == r_tag_handshake) || (i_byte == r_tag_init) ||
                      (i_byte == r_tag_setup);

endmodule

@@ rtl/tag_length_tag_deframer_top.sv @@
// Top level of the tag-length-tag deframer: pending byte buffer and scan sequencer.
//
//  channel    | direction | handshake              | payload
//  -----------+-----------+------------------------+---------------------------------------
//  s stream   | in        | i_s_tvalid/o_s_tready  | tdata: rx_byte
//  m stream   | out       | o_m_tvalid/i_m_tready  | tdata: frame_byte, tuser: type, first;
//             |           |                        | tlast: frame_last
//  config     | in        | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// A byte enters the circular buffer only while idle; each scan step uses the single read
// port: scan and tag steps per dropped byte, tag, length and close steps per candidate
// frame (a too large length ends it in the length steps), one frame byte per cycle while
// taken. A tag waits in idle with under 6 bytes pending or too few for its frame. Reset
// clears the pending count, head and output valid and sets the tag reset values; buffer
// contents are only read where written. A stalled output holds the sequencer in emit.
`include "tag_length_tag_deframer_top_macros.svh"

module tag_length_tag_deframer_top #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Received bytes.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    // Extracted frame bytes.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] frame_byte
    output logic [15:0] o_m_tuser,   // [7:0] frame_type, [8] frame_first, [15:9] zero
    output logic        o_m_tlast,
    // Tag register writes.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import tltd_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
    localparam logic [CW-1:0] MIN_C   = CW'(MIN_FRAME);
    localparam logic [8:0]    DEPTH_9 = 9'(BUFFER_DEPTH);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_TAG   = 4'd2;
    localparam logic [3:0] S_LEN1  = 4'd3;
    localparam logic [3:0] S_LEN2  = 4'd4;
    localparam logic [3:0] S_LEN3  = 4'd5;
    localparam logic [3:0] S_LEN4  = 4'd6;
    localparam logic [3:0] S_CLOSE = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    // Circular index wrap; the sum is always below twice the depth.
    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= DEPTH_S) ? s - DEPTH_S : s;
        return t[AW-1:0];
    endfunction

    logic [BYTE_W-1:0] r_mem [BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_rd_data;

    logic [3:0]        r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [BYTE_W-1:0] r_tag, n_tag;
    logic [BYTE_W-1:0] r_len, n_len;
    logic              r_big, n_big;
    logic [CW-1:0]     r_total, n_total;
    logic [CW-1:0]     r_idx, n_idx;

    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic [BYTE_W-1:0] r_out_type, n_out_type;
    logic              r_out_first, n_out_first;
    logic              r_out_last, n_out_last;

    logic [CW-1:0]     off_sel;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              s_accept;
    logic              out_free;
    logic              is_tag;
    logic              len_big;
    logic [8:0]        tot9;
    logic [CW-1:0]     drop_n;
    t_cfg_wr           cfg_wr;

    assign cfg_wr = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};

    tltd_tag_match u_tag_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_wr),
        .i_byte   (r_rd_data),
        .o_is_tag (is_tag)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    // A full buffer writes over its oldest byte, which is at the head.
    assign wr_addr = wrap(SW'(r_head) + SW'(r_count));
    assign rd_addr = wrap(SW'(r_head) + SW'(off_sel));

    // Length checks on the candidate frame.
    assign len_big = r_big || (r_rd_data != 8'd0);
    assign tot9    = {1'b0, r_len} + 9'(MIN_FRAME);

    // Buffer write and registered read.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mem[wr_addr] <= i_s_tdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Scan sequencer.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_tag       = r_tag;
        n_len       = r_len;
        n_big       = r_big;
        n_total     = r_total;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_byte  = r_out_byte;
        n_out_type  = r_out_type;
        n_out_first = r_out_first;
        n_out_last  = r_out_last;
        off_sel     = '0;
        drop_n      = '0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (r_count == DEPTH_C) begin
                        n_head = wrap(SW'(r_head) + SW'(1));
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                n_state = (r_count == '0) ? S_IDLE : S_TAG;
            end
            S_TAG: begin
                if (!is_tag) begin
                    drop_n  = CW'(1);
                    n_state = S_SCAN;
                end else if (r_count < MIN_C) begin
                    n_state = S_IDLE;
                end else begin
                    n_tag   = r_rd_data;
                    off_sel = CW'(1);
                    n_state = S_LEN1;
                end
            end
            S_LEN1: begin
                n_len   = r_rd_data;
                off_sel = CW'(2);
                n_state = S_LEN2;
            end
            S_LEN2: begin
                n_big   = (r_rd_data != 8'd0);
                off_sel = CW'(3);
                n_state = S_LEN3;
            end
            S_LEN3: begin
                n_big   = len_big;
                off_sel = CW'(4);
                n_state = S_LEN4;
            end
            S_LEN4: begin
                if (len_big || (tot9 > DEPTH_9)) begin
                    drop_n  = CW'(1);
                    n_state = S_SCAN;
                end else if (tot9 > 9'(r_count)) begin
                    n_state = S_IDLE;
                end else begin
                    off_sel = CW'(tot9 - 9'd1);
                    n_total = CW'(tot9);
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                if (r_rd_data != r_tag) begin
                    drop_n  = CW'(1);
                    n_state = S_SCAN;
                end else begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                off_sel = r_idx;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_rd_data;
                    n_out_type  = r_tag;
                    n_out_first = (r_idx == '0);
                    n_out_last  = (r_idx == r_total - CW'(1));
                    if (r_idx == r_total - CW'(1)) begin
                        drop_n  = r_total;
                        n_state = S_SCAN;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        off_sel = r_idx + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Bytes removed from the front of the buffer.
        if (drop_n != '0) begin
            n_head  = wrap(SW'(r_head) + SW'(drop_n));
            n_count = r_count - drop_n;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_tag       <= n_tag;
        r_len       <= n_len;
        r_big       <= n_big;
        r_total     <= n_total;
        r_idx       <= n_idx;
        r_out_byte  <= n_out_byte;
        r_out_type  <= n_out_type;
        r_out_first <= n_out_first;
        r_out_last  <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tuser  = {7'd0, r_out_first, r_out_type};
    assign o_m_tlast  = r_out_last;

    // Checks on the buffer bookkeeping and the emitted frame.
    `TLTD_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C, "pending count over depth")
    `TLTD_ASSERT_NEXT(a_full_stays, i_clk, i_rst_n, s_accept && (r_count == DEPTH_C), r_count == DEPTH_C, "full buffer lost a byte")
    `TLTD_ASSERT_NOW(a_emit_index, i_clk, i_rst_n, r_state == S_EMIT, (r_idx < r_total) && (r_total <= r_count), "emit index past frame")
    `TLTD_ASSERT_NOW(a_first_is_type, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[8], o_m_tdata == o_m_tuser[7:0], "opening byte differs from type")

endmodule
